// File: design/kab_pkg.sv
// Shared types and constants for the angle/bias Kalman filter.
// No dependencies; used by kab_ctrl, kab_dp and kalman_angle_bias_filter.
package kab_pkg;

  localparam int unsigned FracBits = 24;
  localparam int unsigned NoiseW   = 31;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] RegAngleNoise   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBiasNoise    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMeasureNoise = 2'd2;

  localparam logic [NoiseW-1:0] AngleNoiseRst   = 31'd16777;
  localparam logic [NoiseW-1:0] BiasNoiseRst    = 31'd50332;
  localparam logic [NoiseW-1:0] MeasureNoiseRst = 31'd503316;

  // Datapath operations, one per controller step.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,      // latch inputs, rate = sat(m_rate - bias)
    OP_M_DTRATE,  // prod = dt * rate
    OP_A_ANGLE,   // angle = sat(angle + rnd(prod))
    OP_M_DTP11,   // prod = dt * cov_11
    OP_A_INNER,   // dtp11 = rnd(prod); inner = dtp11 - c01 - c10 + an
    OP_M_DTINNER, // prod = dt * inner (inner split in two halves)
    OP_M_DTINH,   // high half partial product
    OP_A_P00,     // p00, p01, p10
    OP_M_BNDT,    // prod = bias_noise * dt
    OP_A_P11,     // p11; s = p00 + R
    OP_DIV0,      // start division for k0
    OP_DIV_STEP,  // one quotient bit
    OP_DIV0_END,  // k0 = sat(quot)
    OP_DIV1,      // start division for k1
    OP_DIV1_END,  // k1 = sat(quot)
    OP_Y,         // y = sat(m_angle - angle)
    OP_M_K0Y,     // prod = k0*y
    OP_A_ANGLE2,
    OP_M_K1Y,
    OP_A_BIAS,
    OP_M_K0P00,
    OP_A_C00,
    OP_M_K0P01,
    OP_A_C01,
    OP_M_K1P00,
    OP_A_C10,
    OP_M_K1P01,
    OP_A_C11
  } kab_op_t;

  typedef struct packed {
    kab_op_t op;
  } kab_cmd_t;

  typedef struct packed {
    logic div_done;
  } kab_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // floor((v + 2^23) / 2^24)
  function automatic logic signed [65:0] rnd(input logic signed [65:0] v);
    logic signed [65:0] a;
    a = v + 66'sd8388608;
    return a >>> FracBits;
  endfunction

endpackage

// File: design/kab_ctrl.sv
// Sequencer for the angle/bias Kalman filter: issues one datapath op per cycle.
// Depends on kab_pkg.
module kab_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output kab_pkg::kab_cmd_t  cmd,
  input  kab_pkg::kab_stat_t stat
);
  import kab_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

  state_t  state_r, state_nxt;
  kab_op_t op_r, op_nxt;
  logic    out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // The input item is latched at the edge that accepts it.
  assign cmd.op    = (state_r == S_RUN) ? op_r :
                     ((state_r == S_IDLE && in_valid) ? OP_LOAD : OP_NOP);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RUN;
          op_nxt    = OP_M_DTRATE;
        end
      end
      S_RUN: begin
        unique case (op_r)
          OP_DIV_STEP: begin
            if (stat.div_done) op_nxt = OP_DIV0_END;
          end
          OP_DIV0_END: op_nxt = OP_DIV1;
          OP_DIV1:     op_nxt = OP_DIV_STEP;
          OP_A_C11: begin
            state_nxt     = S_OUT;
            out_valid_nxt = 1'b1;
            op_nxt        = OP_NOP;
          end
          default: op_nxt = kab_op_t'(op_r + 5'd1);
        endcase
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The division step is shared by both gains; a flag tells which end follows.
  logic second_r, second_nxt;
  always_comb begin
    second_nxt = second_r;
    if (state_r == S_RUN && op_r == OP_DIV0) second_nxt = 1'b0;
    if (state_r == S_RUN && op_r == OP_DIV1) second_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_NOP;
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
      if (state_r == S_RUN && op_r == OP_DIV_STEP && stat.div_done)
        op_r <= second_r ? OP_DIV1_END : OP_DIV0_END;
      else
        op_r <= op_nxt;
    end
  end

endmodule

// File: design/kab_dp.sv
// Datapath of the angle/bias Kalman filter: state, one multiplier, one
// restoring divider. Depends on kab_pkg.
module kab_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kab_pkg::kab_cmd_t                cmd,
  output kab_pkg::kab_stat_t               stat,
  input  logic                             cfg_we,
  input  logic [kab_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [kab_pkg::NoiseW-1:0]       cfg_data,
  input  logic signed [31:0]               in_meas_angle,
  input  logic signed [31:0]               in_meas_rate,
  input  logic [23:0]                      in_step_time,
  output logic signed [31:0]               out_est_angle
);
  import kab_pkg::*;

  logic [NoiseW-1:0] an_r, bn_r, rn_r;
  logic signed [31:0] angle_r, bias_r, c00_r, c01_r, c10_r, c11_r;
  logic signed [31:0] ma_r, rate_r, p00_r, p01_r, p10_r, p11_r, k0_r, k1_r, y_r;
  logic signed [24:0] dt_r;
  logic signed [65:0] prod_r, dtp11_r, inner_r;

  // Divider: |num| = |P|*2^24 < 2^56, |s| < 2^33. One quotient bit a cycle.
  logic [56:0] rem_r, quo_r;
  logic [33:0] den_r;
  logic [5:0]  cnt_r;
  logic        neg_r, zero_r;

  kab_op_t op;
  assign op = cmd.op;
  assign stat.div_done = (cnt_r == 6'd0);
  assign out_est_angle = angle_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] r;
  logic signed [34:0] s_w;
  logic signed [32:0] dnum;
  logic [57:0] trial;
  logic signed [65:0] qs;

  assign r = rnd(prod_r);
  assign s_w = 35'(p00_r) + 35'(signed'({1'b0, rn_r}));
  assign trial = {rem_r[55:0], quo_r[56]} - {24'd0, den_r};
  assign qs = neg_r ? -66'(signed'({1'b0, quo_r})) : 66'(signed'({1'b0, quo_r}));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dnum  = 33'(p00_r);
    unique case (op)
      OP_M_DTRATE:  begin mul_a = 33'(dt_r); mul_b = 33'(rate_r); end
      OP_M_DTP11:   begin mul_a = 33'(dt_r); mul_b = 33'(c11_r); end
      OP_M_DTINNER: begin mul_a = 33'(dt_r); mul_b = signed'({1'b0, inner_r[31:0]}); end
      OP_M_DTINH:   begin mul_a = 33'(dt_r); mul_b = 33'(inner_r[65:32]); end
      OP_M_BNDT:    begin mul_a = 33'(signed'({1'b0, bn_r})); mul_b = 33'(dt_r); end
      OP_M_K0Y:     begin mul_a = 33'(k0_r); mul_b = 33'(y_r); end
      OP_M_K1Y:     begin mul_a = 33'(k1_r); mul_b = 33'(y_r); end
      OP_M_K0P00:   begin mul_a = 33'(k0_r); mul_b = 33'(p00_r); end
      OP_M_K0P01:   begin mul_a = 33'(k0_r); mul_b = 33'(p01_r); end
      OP_M_K1P00:   begin mul_a = 33'(k1_r); mul_b = 33'(p00_r); end
      OP_M_K1P01:   begin mul_a = 33'(k1_r); mul_b = 33'(p01_r); end
      OP_DIV1:      dnum = 33'(p10_r);
      default: ;
    endcase
  end
  assign mul_p = 66'(mul_a) * 66'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      an_r <= AngleNoiseRst;
      bn_r <= BiasNoiseRst;
      rn_r <= MeasureNoiseRst;
      angle_r <= '0; bias_r <= '0;
      c00_r <= '0; c01_r <= '0; c10_r <= '0; c11_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegAngleNoise:   an_r <= cfg_data;
          RegBiasNoise:    bn_r <= cfg_data;
          RegMeasureNoise: rn_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (op)
        OP_LOAD: begin
          ma_r   <= in_meas_angle;
          dt_r   <= 25'(signed'({1'b0, in_step_time}));
          rate_r <= sat32(66'(in_meas_rate) - 66'(bias_r));
        end
        OP_M_DTRATE, OP_M_DTP11, OP_M_BNDT, OP_M_K0Y, OP_M_K1Y,
        OP_M_K0P00, OP_M_K0P01, OP_M_K1P00, OP_M_K1P01, OP_M_DTINNER:
          prod_r <= mul_p;
        OP_M_DTINH: prod_r <= prod_r + (mul_p <<< 32);
        OP_A_ANGLE: angle_r <= sat32(66'(angle_r) + r);
        OP_A_INNER: begin
          dtp11_r <= r;
          inner_r <= r - 66'(c01_r) - 66'(c10_r) + 66'(signed'({1'b0, an_r}));
        end
        OP_A_P00: begin
          p00_r <= sat32(66'(c00_r) + r);
          p01_r <= sat32(66'(c01_r) - dtp11_r);
          p10_r <= sat32(66'(c10_r) - dtp11_r);
        end
        OP_A_P11: p11_r <= sat32(66'(c11_r) + r);
        OP_DIV0, OP_DIV1: begin
          zero_r <= (s_w == '0);
          neg_r  <= dnum[32] ^ s_w[34];
          rem_r  <= '0;
          quo_r  <= {(dnum[32] ? 33'(-dnum) : dnum), 24'd0};
          den_r  <= s_w[34] ? 34'(-s_w) : 34'(s_w);
          cnt_r  <= 6'd57;
        end
        OP_DIV_STEP: begin
          if (cnt_r != 6'd0) begin
            cnt_r <= cnt_r - 6'd1;
            if (!trial[57]) begin
              rem_r <= trial[56:0];
              quo_r <= {quo_r[55:0], 1'b1};
            end else begin
              rem_r <= {rem_r[55:0], quo_r[56]};
              quo_r <= {quo_r[55:0], 1'b0};
            end
          end
        end
        OP_DIV0_END: k0_r <= zero_r ? 32'sd0 : sat32(qs);
        OP_DIV1_END: k1_r <= zero_r ? 32'sd0 : sat32(qs);
        OP_Y:        y_r <= sat32(66'(ma_r) - 66'(angle_r));
        OP_A_ANGLE2: angle_r <= sat32(66'(angle_r) + r);
        OP_A_BIAS:   bias_r <= sat32(66'(bias_r) + r);
        OP_A_C00:    c00_r <= sat32(66'(p00_r) - r);
        OP_A_C01:    c01_r <= sat32(66'(p01_r) - r);
        OP_A_C10:    c10_r <= sat32(66'(p10_r) - r);
        OP_A_C11:    c11_r <= sat32(66'(p11_r) - r);
        default: ;
      endcase
    end
  end

endmodule

// File: design/kalman_angle_bias_filter.sv
// Two-state Kalman filter (tilt angle and gyro bias), top level.
// The input item is latched at the edge that accepts it, and the result is
// offered after 22 sequenced multiply/add steps on one shared 33x33
// multiplier, four steps that start and finish the gain divisions, and
// two bit-serial divisions of 57 quotient bits each plus a finishing step,
// which dominate. A new item is taken only once the result is taken, so
// one item is in flight at a time; a stalled result holds the input.
// Depends on kab_pkg, kab_ctrl, kab_dp.
module kalman_angle_bias_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_meas_angle,
  input  logic signed [31:0]            in_meas_rate,
  input  logic [23:0]                   in_step_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_est_angle,
  input  logic                          cfg_we,
  input  logic [kab_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [kab_pkg::NoiseW-1:0]    cfg_data
);
  import kab_pkg::*;

  kab_cmd_t  cmd;
  kab_stat_t stat;

  kab_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  kab_dp u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
    .in_meas_angle, .in_meas_rate, .in_step_time, .out_est_angle
  );

endmodule

// File: bench/testbench.sv
// Self-checking bench for the two-state angle/bias Kalman filter.
// Depends on kab_pkg and kalman_angle_bias_filter; holds its own fixed-point
// model of the filter and compares every result item against it.

class kab_scoreboard;
  longint angle_q, bias_q, c00, c01, c10, c11;
  longint noise_angle, noise_bias, noise_meas;
  logic signed [31:0] angle_queue[$];
  int errors;

  function new();
    angle_q = 0; bias_q = 0; c00 = 0; c01 = 0; c10 = 0; c11 = 0;
    noise_angle = kab_pkg::AngleNoiseRst;
    noise_bias  = kab_pkg::BiasNoiseRst;
    noise_meas  = kab_pkg::MeasureNoiseRst;
    errors = 0;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q8.24 product back to its format, ties rounded upward.
  function longint round24(longint v);
    return (v + 64'sd8388608) >>> kab_pkg::FracBits;
  endfunction

  function void set_reg(logic [kab_pkg::CfgIdxW-1:0] idx, logic [kab_pkg::NoiseW-1:0] val);
    case (idx)
      kab_pkg::RegAngleNoise:   noise_angle = val;
      kab_pkg::RegBiasNoise:    noise_bias = val;
      kab_pkg::RegMeasureNoise: noise_meas = val;
      default: ;
    endcase
  endfunction

  function void note_item(logic signed [31:0] m_angle, logic signed [31:0] m_rate,
                          logic [23:0] step);
    longint d, rate, dtp11, inner, p00, p01, p10, p11, s, k0, k1, y;
    d = step;
    rate = clamp32(longint'(m_rate) - bias_q);
    angle_q = clamp32(angle_q + round24(d * rate));
    dtp11 = round24(d * c11);
    inner = dtp11 - c01 - c10 + noise_angle;
    p00 = clamp32(c00 + round24(d * inner));
    p01 = clamp32(c01 - dtp11);
    p10 = clamp32(c10 - dtp11);
    p11 = clamp32(c11 + round24(noise_bias * d));
    s = p00 + noise_meas;
    k0 = 0;
    k1 = 0;
    // A zero innovation variance leaves the prediction untouched.
    if (s != 0) begin
      k0 = clamp32((p00 * (64'sd1 << kab_pkg::FracBits)) / s);
      k1 = clamp32((p10 * (64'sd1 << kab_pkg::FracBits)) / s);
    end
    y = clamp32(longint'(m_angle) - angle_q);
    angle_q = clamp32(angle_q + round24(k0 * y));
    bias_q = clamp32(bias_q + round24(k1 * y));
    c00 = clamp32(p00 - round24(k0 * p00));
    c01 = clamp32(p01 - round24(k0 * p01));
    c10 = clamp32(p10 - round24(k1 * p00));
    c11 = clamp32(p11 - round24(k1 * p01));
    angle_queue.push_back(angle_q[31:0]);
  endfunction

  function void check_result(logic signed [31:0] got);
    logic signed [31:0] want;
    if (angle_queue.size() == 0) begin
      $display("%0t: unexpected result item est_angle=%0d", $time, got);
      errors++;
      return;
    end
    want = angle_queue.pop_front();
    if (got !== want) begin
      $display("%0t: est_angle mismatch, expected %0d, actual %0d", $time, want, got);
      errors++;
    end
  endfunction

  function int pending();
    return angle_queue.size();
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kab_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_meas_angle = '0;
  logic signed [31:0] in_meas_rate = '0;
  logic [23:0] in_step_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_est_angle;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [NoiseW-1:0] cfg_data = '0;

  kab_scoreboard tilt_sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_req = 0;
  int recv_hold_cnt = 0;
  longint true_angle = 0;

  kalman_angle_bias_filter u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (recv_hold_req > 0) begin
      recv_hold_cnt = recv_hold_req;
      recv_hold_req = 0;
    end
    if (recv_hold_cnt > 0) begin
      recv_hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tilt_sb.check_result(out_est_angle);
  end

  task automatic send_item(logic signed [31:0] m_angle, logic signed [31:0] m_rate,
                           logic [23:0] step);
    if (in_valid && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_meas_angle <= m_angle;
    in_meas_rate <= m_rate;
    in_step_time <= step;
    do @(posedge clk); while (!in_ready);
    tilt_sb.note_item(m_angle, m_rate, step);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tilt_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [NoiseW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tilt_sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Mostly a plausible tilt trace at a few ms per sample; the rest is noise.
  task automatic send_random();
    logic signed [31:0] a, r;
    logic [23:0] dt;
    if ($urandom_range(99) < 75) begin
      true_angle = true_angle + $signed($urandom_range(0, 131072)) - 65536;
      if (true_angle > 90 * 65536 || true_angle < -90 * 65536) true_angle = 0;
      a = 32'(true_angle + $signed($urandom_range(0, 262144)) - 131072);
      r = $signed($urandom_range(0, 100 * 65536)) - 50 * 65536;
      dt = 24'($urandom_range(1000, 400000));
    end else begin
      a = $urandom;
      r = $urandom;
      dt = 24'($urandom);
    end
    send_item(a, r, dt);
  endtask

  initial begin
    logic [NoiseW-1:0] set_an, set_bn, set_mn;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items: field extremes and saturation with reset noise values.
    send_item(0, 0, 0);
    send_item(32'sh7fffffff, 32'sh7fffffff, 24'hffffff);
    send_item(32'sh80000000, 32'sh80000000, 24'hffffff);
    send_item(32'sh7fffffff, 32'sh80000000, 24'h000001);
    send_item(32'sh80000000, 32'sh7fffffff, 24'h800000);
    send_item(32'sh00010000, 32'sh00000000, 24'd167772);
    send_item(-32'sh00010000, 32'sh00050000, 24'd16777);
    drain();
    cfg_write(RegAngleNoise, '1);
    cfg_write(RegBiasNoise, '1);
    cfg_write(RegMeasureNoise, 31'd1);
    cfg_write(2'd3, 31'h55555555);
    send_item(32'sh7fffffff, 32'sh7fffffff, 24'hffffff);
    send_item(32'sh80000000, 32'sh80000000, 24'hffffff);
    send_item(0, 0, 24'hffffff);
    send_item(32'sh12345678, -32'sh00ABCDEF, 24'h0F0F0F);
    drain();
    cfg_write(RegAngleNoise, '0);
    cfg_write(RegBiasNoise, '0);
    cfg_write(RegMeasureNoise, '1);
    send_item(32'sh00640000, 0, 24'hffffff);
    send_item(-32'sh00640000, 32'sh7fffffff, 24'h000000);
    send_item(32'sh7fffffff, 0, 24'hffffff);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin set_an = 0; set_bn = 0; set_mn = 1; end
        1: begin set_an = '1; set_bn = '1; set_mn = '1; end
        2, 3: begin
          set_an = AngleNoiseRst; set_bn = BiasNoiseRst; set_mn = MeasureNoiseRst;
        end
        default: begin
          set_an = 31'($urandom_range(0, 1 << 22));
          set_bn = 31'($urandom_range(0, 1 << 22));
          set_mn = 31'($urandom_range(1, 1 << 24));
        end
      endcase
      cfg_write(RegAngleNoise, set_an);
      cfg_write(RegBiasNoise, set_bn);
      cfg_write(RegMeasureNoise, set_mn);
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 80 : 17) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 80 : 17) : 0;
      // Hold the result side off for a long stretch so the input backs up.
      if (ph == 2) recv_hold_req = 600;
      for (int n = 0; n < 190; n++) send_random();
    end
    in_valid <= 1'b0;
    while (tilt_sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (tilt_sb.errors == 0 && tilt_sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end
endmodule
